[src/imsc_pkg.sv]
// imsc_pkg: shared types, constants and helpers of the imu sample calibration block
// used by every module of the block; no dependencies
`default_nettype none

package imsc_pkg;

  localparam int TABLE_DEPTH      = 27;
  localparam int LANES            = 3;
  localparam int BANK_DEPTH       = 9;
  localparam int DIV_STEPS        = 17;
  localparam int SQRT_STEPS       = 32;
  localparam int CFG_ADDR_W       = 5;
  localparam int DEF_COEF_WIDTH   = 32;
  localparam int DEF_SAMPLE_WIDTH = 16;
  localparam logic [31:0] DEG2RAD_Q32 = 32'd74961321;

  typedef enum logic [1:0] {K_GYRO, K_ACCEL, K_MAG, K_COEF} func_t;

  typedef enum logic [2:0] {
    REG_FILT_EN, REG_ALPHA, REG_GYRO_SCALE, REG_ACCEL_SCALE, REG_MAG_SCALE
  } reg_idx_t;

  typedef enum logic [2:0] {S_IDLE, S_RUN, S_SQ, S_SQRT, S_DIV, S_DONE} state_t;

  // coefficient slots inside one lane bank
  localparam logic [3:0] LOC_MAG_OFF   = 4'd0;
  localparam logic [3:0] LOC_MAG_ROW   = 4'd1;
  localparam logic [3:0] LOC_ACC_OFF   = 4'd4;
  localparam logic [3:0] LOC_ACC_ROW   = 4'd5;
  localparam logic [3:0] LOC_GYRO_BIAS = 4'd8;

  typedef enum logic [2:0] {A_RAW, A_VAL, A_VEC0, A_VEC1, A_VEC2, A_POUT, A_PIN} asel_t;
  typedef enum logic [2:0] {B_SCALE, B_DEG, B_HI, B_LO, B_AINV, B_ALPHA, B_VAL} bsel_t;
  typedef enum logic [3:0] {
    C_NOP, C_SH16, C_SH32, C_SUBC, C_RAWOFF, C_LOAD, C_KEEP, C_QACC,
    C_ACCOUT, C_FILT, C_DIVINIT, C_DIVSTEP, C_DIVOUT
  } cop_t;

  typedef struct packed {
    logic       mul;
    asel_t      asel;
    bsel_t      bsel;
    logic [3:0] loc;
    cop_t       cop;
    logic       aclr;
    logic       filt;
    logic       last;
  } lane_ctrl_t;

  typedef struct packed {
    logic [1:0] lane;
    logic [3:0] loc;
  } coef_map_t;

  localparam lane_ctrl_t NOP_CTRL = '{
    mul: 1'b0, asel: A_RAW, bsel: B_SCALE, loc: 4'd0, cop: C_NOP,
    aclr: 1'b0, filt: 1'b0, last: 1'b0
  };

  function automatic logic signed [31:0] sat32(input logic signed [69:0] x);
    if (x > 70'sd2147483647) return 32'sh7fffffff;
    if (x < -70'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
    return (v == 32'sh80000000) ? 32'sh7fffffff : -v;
  endfunction

  function automatic lane_ctrl_t mk(input logic m, input asel_t a, input bsel_t b,
                                    input logic [3:0] loc, input cop_t c);
    lane_ctrl_t r;
    r = NOP_CTRL;
    r.mul  = m;
    r.asel = a;
    r.bsel = b;
    r.loc  = loc;
    r.cop  = c;
    return r;
  endfunction

  // one row-times-vector product: high-half multiply, low-half multiply and accumulate per column
  function automatic lane_ctrl_t mat(input logic [3:0] rel, input logic [3:0] base);
    lane_ctrl_t c;
    c = NOP_CTRL;
    case (rel)
      4'd0: begin
        c = mk(1'b1, A_VEC0, B_HI, base, C_NOP);
        c.aclr = 1'b1;
      end
      4'd1: c = mk(1'b1, A_VEC0, B_LO, base, C_KEEP);
      4'd2: c = mk(1'b0, A_VAL, B_VAL, base, C_QACC);
      4'd3: c = mk(1'b1, A_VEC1, B_HI, base + 4'd1, C_NOP);
      4'd4: c = mk(1'b1, A_VEC1, B_LO, base + 4'd1, C_KEEP);
      4'd5: c = mk(1'b0, A_VAL, B_VAL, base, C_QACC);
      4'd6: c = mk(1'b1, A_VEC2, B_HI, base + 4'd2, C_NOP);
      4'd7: c = mk(1'b1, A_VEC2, B_LO, base + 4'd2, C_KEEP);
      4'd8: c = mk(1'b0, A_VAL, B_VAL, base, C_QACC);
      default: c = NOP_CTRL;
    endcase
    return c;
  endfunction

  function automatic lane_ctrl_t ucode(input func_t k, input logic [4:0] s);
    lane_ctrl_t c;
    c = NOP_CTRL;
    case (k)
      K_GYRO: begin
        case (s)
          5'd0: c = mk(1'b1, A_RAW, B_SCALE, 4'd0, C_NOP);
          5'd1: c = mk(1'b0, A_VAL, B_VAL, 4'd0, C_SH16);
          5'd2: c = mk(1'b0, A_VAL, B_VAL, LOC_GYRO_BIAS, C_SUBC);
          5'd3: c = mk(1'b1, A_VAL, B_DEG, 4'd0, C_NOP);
          5'd4: c = mk(1'b0, A_VAL, B_VAL, 4'd0, C_SH32);
          5'd5: begin
            c = mk(1'b0, A_VAL, B_VAL, 4'd0, C_LOAD);
            c.last = 1'b1;
          end
          default: c = NOP_CTRL;
        endcase
      end
      K_ACCEL: begin
        if (s >= 5'd4 && s <= 5'd12) begin
          c = mat(4'(s - 5'd4), LOC_ACC_ROW);
        end else begin
          case (s)
            5'd0: c = mk(1'b1, A_RAW, B_SCALE, 4'd0, C_NOP);
            5'd1: c = mk(1'b0, A_VAL, B_VAL, 4'd0, C_SH16);
            5'd2: c = mk(1'b0, A_VAL, B_VAL, 4'd0, C_LOAD);
            5'd3: c = mk(1'b0, A_VAL, B_VAL, LOC_ACC_OFF, C_SUBC);
            5'd13: begin
              c = mk(1'b0, A_VAL, B_VAL, 4'd0, C_ACCOUT);
              c.last = 1'b1;
            end
            default: c = NOP_CTRL;
          endcase
        end
      end
      K_MAG: begin
        if (s >= 5'd1 && s <= 5'd9) begin
          c = mat(4'(s - 5'd1), LOC_MAG_ROW);
        end else begin
          case (s)
            5'd0:  c = mk(1'b0, A_VAL, B_VAL, LOC_MAG_OFF, C_RAWOFF);
            5'd10: c = mk(1'b0, A_VAL, B_VAL, 4'd0, C_ACCOUT);
            5'd11: c = mk(1'b1, A_VAL, B_SCALE, 4'd0, C_NOP);
            5'd12: c = mk(1'b0, A_VAL, B_VAL, 4'd0, C_SH32);
            5'd13: c = mk(1'b0, A_VAL, B_VAL, 4'd0, C_LOAD);
            5'd14: begin
              c = mk(1'b1, A_POUT, B_AINV, 4'd0, C_NOP);
              c.filt = 1'b1;
            end
            5'd15: begin
              c = mk(1'b1, A_PIN, B_ALPHA, 4'd0, C_KEEP);
              c.filt = 1'b1;
            end
            5'd16: begin
              c = mk(1'b0, A_VAL, B_VAL, 4'd0, C_FILT);
              c.filt = 1'b1;
            end
            5'd17: begin
              c = mk(1'b1, A_VAL, B_VAL, 4'd0, C_NOP);
              c.last = 1'b1;
            end
            default: c = NOP_CTRL;
          endcase
        end
      end
      default: c = NOP_CTRL;
    endcase
    return c;
  endfunction

  function automatic coef_map_t row_split(input logic [4:0] d, input logic [3:0] base);
    coef_map_t m;
    if (d >= 5'd6) begin
      m.lane = 2'd2;
      m.loc  = base + 4'(d - 5'd6);
    end else if (d >= 5'd3) begin
      m.lane = 2'd1;
      m.loc  = base + 4'(d - 5'd3);
    end else begin
      m.lane = 2'd0;
      m.loc  = base + 4'(d);
    end
    return m;
  endfunction

  // global table index to lane and slot
  function automatic coef_map_t coef_map(input logic [4:0] idx);
    coef_map_t m;
    if (idx < 5'd3) begin
      m.lane = idx[1:0];
      m.loc  = LOC_MAG_OFF;
    end else if (idx < 5'd12) begin
      m = row_split(idx - 5'd3, LOC_MAG_ROW);
    end else if (idx < 5'd15) begin
      m.lane = 2'(idx - 5'd12);
      m.loc  = LOC_ACC_OFF;
    end else if (idx < 5'd24) begin
      m = row_split(idx - 5'd15, LOC_ACC_ROW);
    end else begin
      m.lane = 2'(idx - 5'd24);
      m.loc  = LOC_GYRO_BIAS;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[src/imsc_item_if.sv]
// imsc_item_if: input channel of the imu sample calibration block
// valid/ready handshake carrying one raw sample or one table write
`default_nettype none

interface imsc_item_if #(
  parameter int SW = 16
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           func;
  logic signed [SW-1:0] raw_x;
  logic signed [SW-1:0] raw_y;
  logic signed [SW-1:0] raw_z;
  logic [4:0]           coef_index;
  logic signed [31:0]   coef_value;

  modport source (output valid, func, raw_x, raw_y, raw_z, coef_index, coef_value,
                  input ready);
  modport sink   (input valid, func, raw_x, raw_y, raw_z, coef_index, coef_value,
                  output ready);
endinterface

`default_nettype wire

[src/imsc_result_if.sv]
// imsc_result_if: output channel of the imu sample calibration block
// valid/ready handshake carrying one calibrated ned vector
`default_nettype none

interface imsc_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] north;
  logic signed [31:0] east;
  logic signed [31:0] down;
  logic               zero_norm;

  modport source (output valid, kind, north, east, down, zero_norm, input ready);
  modport sink   (input valid, kind, north, east, down, zero_norm, output ready);
endinterface

`default_nettype wire

[src/imu_sample_calibration.sv]
// imu_sample_calibration: top level with sequencer, three axis lanes, ned remap,
// square root merging stage, output register and apb register file
// depends on imsc_pkg, imsc_item_if, imsc_result_if, imsc_lane, imsc_sqrt
//
// item channel: one raw gyro, accel or mag sample, or a calibration table write
// (func 3), per transfer. result channel: one ned vector per sample; table
// writes give no result and are absorbed in the cycle they are taken.
// registers are written over the apb port; the user must write them only while
// the block is idle, which the block itself does not enforce.
// a mag sample runs 18 datapath steps, then the 32-step square root, then the
// 17-step quotient divide in all three lanes at once (skipped when the root is
// zero), and then loads the output register.
// one sample is worked on at a time; the lane multipliers are shared over the
// steps, and the square root and divider loops run only for mag samples.
// a finished result waits in the output register while the next sample is
// taken; if the receiver stalls and a second result is finished, the
// sequencer holds it until the register frees up.
// reset clears the calibration table, the mag filter history, the registers
// and the output valid.
`default_nettype none

module imu_sample_calibration #(
  parameter int COEF_WIDTH   = imsc_pkg::DEF_COEF_WIDTH,
  parameter int SAMPLE_WIDTH = imsc_pkg::DEF_SAMPLE_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  imsc_item_if.sink                              item,
  imsc_result_if.source                          result,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [imsc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import imsc_pkg::*;

  state_t state;
  state_t state_next;

  logic        mag_filter_enable;
  logic [15:0] filter_alpha;
  logic [31:0] gyro_scale;
  logic [31:0] accel_scale;
  logic [31:0] mag_scale;

  func_t      kind_q;
  logic [4:0] step;
  logic [4:0] divcnt;
  logic       zflag;
  logic       out_valid;
  logic [31:0] mag_q;
  logic [LANES-1:0][SAMPLE_WIDTH-1:0] raw_q;

  lane_ctrl_t ctrl;
  lane_ctrl_t run_ctrl;
  logic       accept;
  logic       load_out;
  logic       sqrt_start;
  logic       sq_done;
  logic [31:0] root;
  logic [63:0] sumsq;
  logic [31:0] scale_sel;

  logic [LANES-1:0][31:0] vals;
  logic [LANES-1:0][31:0] ld;
  logic [LANES-1:0][63:0] sqs;

  logic              coef_we;
  coef_map_t         cmap;
  logic signed [47:0] coef_wide;
  reg_idx_t          reg_idx;

  assign item.ready   = (state == S_IDLE);
  assign accept       = item.valid && (state == S_IDLE);
  assign result.valid = out_valid;
  assign pready       = 1'b1;
  assign reg_idx      = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

  assign coef_we   = accept && (func_t'(item.func) == K_COEF)
                     && (item.coef_index < 5'(TABLE_DEPTH));
  assign cmap      = coef_map(item.coef_index);
  assign coef_wide = 48'(item.coef_value);
  assign run_ctrl  = ucode(kind_q, step);
  assign sumsq     = sqs[0] + sqs[1] + sqs[2];

  always_comb begin
    case (kind_q)
      K_GYRO:  scale_sel = gyro_scale;
      K_ACCEL: scale_sel = accel_scale;
      K_MAG:   scale_sel = mag_scale;
      default: scale_sel = '0;
    endcase
  end

  // ned remap
  assign ld[0] = vals[2];
  assign ld[1] = neg_sat(signed'(vals[1]));
  assign ld[2] = (kind_q == K_MAG) ? vals[0] : neg_sat(signed'(vals[0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = NOP_CTRL;
    sqrt_start = 1'b0;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept && func_t'(item.func) != K_COEF) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        ctrl = run_ctrl;
        if (run_ctrl.filt && !mag_filter_enable) begin
          ctrl.mul = 1'b0;
          ctrl.cop = C_NOP;
        end
        if (run_ctrl.last) begin
          state_next = (kind_q == K_MAG) ? S_SQ : S_DONE;
        end
      end
      S_SQ: begin
        sqrt_start = 1'b1;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        if (sq_done) begin
          state_next = (root == 32'd0) ? S_DONE : S_DIV;
        end
      end
      S_DIV: begin
        if (divcnt == 5'd0) begin
          ctrl.cop = C_DIVINIT;
        end else if (divcnt == 5'(DIV_STEPS + 1)) begin
          ctrl.cop   = C_DIVOUT;
          state_next = S_DONE;
        end else begin
          ctrl.cop = C_DIVSTEP;
        end
      end
      S_DONE: begin
        if (!out_valid || result.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      step              <= '0;
      divcnt            <= '0;
      zflag             <= 1'b0;
      mag_filter_enable <= 1'b0;
      filter_alpha      <= '0;
      gyro_scale        <= '0;
      accel_scale       <= '0;
      mag_scale         <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      step   <= (state == S_RUN) ? step + 5'd1 : 5'd0;
      divcnt <= (state == S_DIV) ? divcnt + 5'd1 : 5'd0;
      if (accept) begin
        zflag <= 1'b0;
      end else if (state == S_SQRT && sq_done) begin
        zflag <= (root == 32'd0);
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx)
          REG_FILT_EN:     mag_filter_enable <= pwdata[0];
          REG_ALPHA:       filter_alpha      <= pwdata[15:0];
          REG_GYRO_SCALE:  gyro_scale        <= pwdata;
          REG_ACCEL_SCALE: accel_scale       <= pwdata;
          REG_MAG_SCALE:   mag_scale         <= pwdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q   <= func_t'(item.func);
      raw_q[0] <= item.raw_x;
      raw_q[1] <= item.raw_y;
      raw_q[2] <= item.raw_z;
    end
    if (state == S_SQRT && sq_done) begin
      mag_q <= root;
    end
    if (load_out) begin
      result.kind      <= kind_q;
      result.north     <= zflag ? 32'sd0 : signed'(vals[0]);
      result.east      <= zflag ? 32'sd0 : signed'(vals[1]);
      result.down      <= zflag ? 32'sd0 : signed'(vals[2]);
      result.zero_norm <= zflag;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FILT_EN:     prdata = {31'd0, mag_filter_enable};
      REG_ALPHA:       prdata = {16'd0, filter_alpha};
      REG_GYRO_SCALE:  prdata = gyro_scale;
      REG_ACCEL_SCALE: prdata = accel_scale;
      REG_MAG_SCALE:   prdata = mag_scale;
      default:         prdata = '0;
    endcase
  end

  for (genvar gi = 0; gi < LANES; gi++) begin : g_lane
    imsc_lane #(
      .CW (COEF_WIDTH),
      .SW (SAMPLE_WIDTH)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .raw     (raw_q[gi]),
      .scale   (scale_sel),
      .alpha   (filter_alpha),
      .vec     (vals),
      .ld      (ld[gi]),
      .mag     (mag_q),
      .wr_en   (coef_we && cmap.lane == 2'(gi)),
      .wr_loc  (cmap.loc),
      .wr_data (coef_wide[COEF_WIDTH-1:0]),
      .val     (vals[gi]),
      .sq      (sqs[gi])
    );
  end

  imsc_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .x     (sumsq),
    .done  (sq_done),
    .root  (root)
  );

  a_zero_kind: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.zero_norm |-> result.kind == K_MAG)
    else $error("zero_norm on a non-mag result");

  a_zero_vec: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.zero_norm |->
      result.north == 32'sd0 && result.east == 32'sd0 && result.down == 32'sd0)
    else $error("zero_norm result with nonzero components");

  a_sqrt_mag: assert property (@(posedge clk) disable iff (rst)
    state == S_SQRT |-> kind_q == K_MAG)
    else $error("square root run for a non-mag sample");

endmodule

`default_nettype wire

[src/imsc_lane.sv]
// imsc_lane: one axis lane with its coefficient bank, multiplier, accumulator,
// filter state and quotient divider; depends on imsc_pkg
`default_nettype none

module imsc_lane #(
  parameter int CW = 32,
  parameter int SW = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire imsc_pkg::lane_ctrl_t                    ctrl,
  input  wire logic signed [SW-1:0]                    raw,
  input  wire logic [31:0]                             scale,
  input  wire logic [15:0]                             alpha,
  input  wire logic [imsc_pkg::LANES-1:0][31:0]        vec,
  input  wire logic signed [31:0]                      ld,
  input  wire logic [31:0]                             mag,
  input  wire logic                                    wr_en,
  input  wire logic [3:0]                              wr_loc,
  input  wire logic [CW-1:0]                           wr_data,
  output logic signed [31:0]                           val,
  output logic [63:0]                                  sq
);
  import imsc_pkg::*;

  logic [BANK_DEPTH-1:0][CW-1:0] bank;
  logic [CW-1:0]        coef_sel;
  logic signed [CW-1:0] coef_s;
  logic signed [47:0]   coef_ext;
  logic signed [47:0]   coef_hi;
  logic [16:0]          ainv;
  logic signed [33:0]   opa;
  logic signed [33:0]   opb;
  logic signed [67:0]   prod;
  logic signed [67:0]   tmp;
  logic signed [35:0]   acc;
  logic signed [31:0]   pin;
  logic signed [31:0]   pout;
  logic signed [31:0]   filt_val;
  logic [31:0]          absv;
  logic [32:0]          rem;
  logic [16:0]          dbits;
  logic [16:0]          quo;
  logic                 neg;
  logic [33:0]          trial;

  assign coef_sel = (ctrl.loc < 4'(BANK_DEPTH)) ? bank[ctrl.loc] : '0;
  assign coef_s   = coef_sel;
  assign coef_ext = 48'(coef_s);
  assign coef_hi  = coef_ext >>> 16;
  assign ainv     = 17'h10000 - {1'b0, alpha};
  assign absv     = val[31] ? (~val + 32'd1) : val;
  assign trial    = {rem, dbits[16]};
  assign filt_val = sat32((70'(tmp) + 70'(prod)) >>> 16);
  assign sq       = prod[63:0];

  always_comb begin
    case (ctrl.asel)
      A_RAW:   opa = 34'(raw);
      A_VAL:   opa = 34'(val);
      A_VEC0:  opa = 34'(signed'(vec[0]));
      A_VEC1:  opa = 34'(signed'(vec[1]));
      A_VEC2:  opa = 34'(signed'(vec[2]));
      A_POUT:  opa = 34'(pout);
      A_PIN:   opa = 34'(pin);
      default: opa = '0;
    endcase
    case (ctrl.bsel)
      B_SCALE: opb = 34'(scale);
      B_DEG:   opb = 34'(DEG2RAD_Q32);
      B_HI:    opb = 34'(coef_hi);
      B_LO:    opb = 34'(coef_ext[15:0]);
      B_AINV:  opb = 34'(ainv);
      B_ALPHA: opb = 34'(alpha);
      B_VAL:   opb = 34'(val);
      default: opb = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= '0;
      pin  <= '0;
      pout <= '0;
    end else begin
      if (wr_en && wr_loc < 4'(BANK_DEPTH)) begin
        bank[wr_loc] <= wr_data;
      end
      if (ctrl.cop == C_FILT) begin
        pin  <= val;
        pout <= filt_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod <= opa * opb;
    end
    if (ctrl.aclr) begin
      acc <= '0;
    end
    case (ctrl.cop)
      C_SH16:   val <= sat32(70'(prod >>> 16));
      C_SH32:   val <= sat32(70'(prod >>> 32));
      C_SUBC:   val <= sat32(70'(val) - 70'(coef_ext));
      C_RAWOFF: val <= sat32((70'(raw) <<< 16) - 70'(coef_ext));
      C_LOAD:   val <= ld;
      C_KEEP:   tmp <= prod;
      C_QACC:   acc <= acc + 36'(sat32(70'(tmp) + 70'(prod >>> 16)));
      C_ACCOUT: val <= sat32(70'(acc));
      C_FILT:   val <= filt_val;
      C_DIVINIT: begin
        rem   <= 33'(absv >> 1);
        dbits <= {absv[0], 16'd0};
        quo   <= '0;
        neg   <= val[31];
      end
      C_DIVSTEP: begin
        if (trial >= {2'b00, mag}) begin
          rem <= 33'(trial - {2'b00, mag});
          quo <= {quo[15:0], 1'b1};
        end else begin
          rem <= trial[32:0];
          quo <= {quo[15:0], 1'b0};
        end
        dbits <= {dbits[15:0], 1'b0};
      end
      C_DIVOUT: val <= neg ? -signed'(32'(quo)) : signed'(32'(quo));
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[src/imsc_sqrt.sv]
// imsc_sqrt: merging stage, floor square root of the lanes' summed squares
// settles one result bit from each input bit pair, one root at a time; depends on imsc_pkg
`default_nettype none

module imsc_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] x,
  output logic             done,
  output logic [31:0]      root
);
  import imsc_pkg::*;

  localparam int CNT_W = $clog2(SQRT_STEPS);

  logic [63:0]      xr;
  logic [63:0]      res;
  logic [63:0]      bitv;
  logic [64:0]      trial;
  logic [CNT_W-1:0] cnt;
  logic             run;

  assign trial = 65'(res) + 65'(bitv);
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SQRT_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr   <= x;
      res  <= '0;
      bitv <= 64'd1 << 62;
    end else if (run) begin
      if (65'(xr) >= trial) begin
        xr  <= xr - trial[63:0];
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

`default_nettype wire

[bench/testbench.sv]
// testbench: self-checking bench for imu_sample_calibration
// drives raw samples, table writes and register writes, predicts ned results with a local model
// depends on imsc_pkg, imsc_item_if, imsc_result_if and the block rtl
`timescale 1ns / 100ps

module testbench;
  import imsc_pkg::*;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  imsc_item_if #(.SW(16)) item_ch ();
  imsc_result_if result_ch ();

  imu_sample_calibration i_dut (
    .clk(clk), .rst(rst), .item(item_ch.sink), .result(result_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] north;
    logic signed [31:0] east;
    logic signed [31:0] down;
    logic               zero_norm;
  } ned_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [4:0]         idx;
    logic signed [31:0] value;
    logic               known;
    ned_t               want;
  } row_t;

  // model state
  logic signed [31:0] coef_tab [TABLE_DEPTH];
  longint prev_in [3];
  longint prev_out [3];
  logic   filt_en;
  logic [15:0] alpha;
  logic [31:0] gscale, ascale, mscale;

  ned_t   expected_ned [$];
  int     errors;
  int     n_sent, n_seen, n_mag, n_zero;
  int     idle_cnt;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint sat(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    longint hi, lo;
    hi = a >>> 16;
    lo = a - hi * 65536;
    return sat(hi * b + ((lo * b) >>> 16));
  endfunction

  function automatic longint scale_cnt(input longint raw, input logic [31:0] s);
    return sat((raw * longint'({32'd0, s})) >>> 16);
  endfunction

  function automatic longint mul_frac(input longint v, input logic [31:0] s);
    return sat((v * longint'({32'd0, s})) >>> 32);
  endfunction

  function automatic longint root64(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  task automatic soft_iron(input int base, input longint v[3], output longint r[3]);
    for (int i = 0; i < 3; i++)
      r[i] = sat(qmul(coef_tab[base + 3*i], v[0]) + qmul(coef_tab[base + 3*i + 1], v[1])
                 + qmul(coef_tab[base + 3*i + 2], v[2]));
  endtask

  // updates model state; returns 1 when a result follows
  task automatic calibrate(input row_t t, output bit has, output ned_t o);
    longint raw[3], v[3], m[3], r[3], s[3];
    longint g, f, a;
    longint unsigned sumsq, mg;
    longint mag;
    o = '0;
    has = 1'b0;
    if (func_t'(t.func) == K_COEF) begin
      if (t.idx < TABLE_DEPTH) coef_tab[t.idx] = t.value;
      return;
    end
    has = 1'b1;
    raw[0] = t.x; raw[1] = t.y; raw[2] = t.z;
    if (func_t'(t.func) == K_GYRO) begin
      for (int i = 0; i < 3; i++) begin
        g = scale_cnt(raw[i], gscale);
        g = sat(g - coef_tab[24 + i]);
        v[i] = mul_frac(g, DEG2RAD_Q32);
      end
      r[0] = v[2]; r[1] = sat(-v[1]); r[2] = sat(-v[0]);
    end else if (func_t'(t.func) == K_ACCEL) begin
      for (int i = 0; i < 3; i++) s[i] = scale_cnt(raw[i], ascale);
      v[0] = s[2]; v[1] = sat(-s[1]); v[2] = sat(-s[0]);
      for (int i = 0; i < 3; i++) v[i] = sat(v[i] - coef_tab[12 + i]);
      soft_iron(15, v, r);
    end else begin
      n_mag++;
      for (int i = 0; i < 3; i++) v[i] = sat(raw[i] * 65536 - coef_tab[i]);
      soft_iron(3, v, m);
      for (int i = 0; i < 3; i++) m[i] = mul_frac(m[i], mscale);
      r[0] = m[2]; r[1] = sat(-m[1]); r[2] = m[0];
      if (filt_en) begin
        a = alpha;
        for (int i = 0; i < 3; i++) begin
          f = sat(((65536 - a) * prev_out[i] + a * prev_in[i]) >>> 16);
          prev_in[i] = r[i];
          prev_out[i] = f;
          r[i] = f;
        end
      end
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
        mg = longint'(r[i] < 0 ? -r[i] : r[i]);
        sumsq += mg * mg;
      end
      mag = root64(sumsq);
      if (mag == 0) begin
        o.zero_norm = 1'b1;
        n_zero++;
        for (int i = 0; i < 3; i++) r[i] = 0;
      end else begin
        for (int i = 0; i < 3; i++) r[i] = (r[i] * 65536) / mag;
      end
    end
    o.kind = t.func;
    o.north = r[0][31:0];
    o.east = r[1][31:0];
    o.down = r[2][31:0];
  endtask

  task automatic report(input string what, input ned_t got, input ned_t want);
    errors++;
    $display("mismatch %s: got %0d %0d %0d %0d z%0d want %0d %0d %0d %0d z%0d", what,
             got.kind, got.north, got.east, got.down, got.zero_norm,
             want.kind, want.north, want.east, want.down, want.zero_norm);
  endtask

  // result side: random stalls and checking
  int stall;
  initial begin
    result_ch.ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        ned_t got, want;
        got = '{result_ch.kind, result_ch.north, result_ch.east, result_ch.down,
                result_ch.zero_norm};
        n_seen++;
        if (expected_ned.size() == 0) begin
          report("unexpected transfer", got, '0);
        end else begin
          want = expected_ned.pop_front();
          if (got.kind != want.kind) report("kind", got, want);
          else if (got.north != want.north) report("north", got, want);
          else if (got.east != want.east) report("east", got, want);
          else if (got.down != want.down) report("down", got, want);
          else if (got.zero_norm != want.zero_norm) report("zero_norm", got, want);
        end
      end
      if (stall > 0) begin
        stall--;
        result_ch.ready <= 1'b0;
      end else if (n_sent > 300 && n_sent < 400) begin
        result_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 9) < 3) begin
        stall = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 4);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    idle_cnt = 0;
    forever begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        idle_cnt = 0;
      else
        idle_cnt++;
      if (idle_cnt > 5000) begin
        $display("watchdog expired");
        $display("testbench: errors");
        $finish;
      end
    end
  end

  task automatic reg_write(input reg_idx_t r, input logic [31:0] d);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(4 * int'(r)); pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    idle_cnt = 0;
    case (r)
      REG_FILT_EN: filt_en = d[0];
      REG_ALPHA: alpha = d[15:0];
      REG_GYRO_SCALE: gscale = d;
      REG_ACCEL_SCALE: ascale = d;
      default: mscale = d;
    endcase
  endtask

  task automatic settle();
    while (expected_ned.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic send(input row_t t);
    bit has;
    ned_t o;
    int gap;
    gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 2);
    if (n_sent > 300 && n_sent < 400) gap = 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.func <= t.func;
    item_ch.raw_x <= t.x; item_ch.raw_y <= t.y; item_ch.raw_z <= t.z;
    item_ch.coef_index <= t.idx;
    item_ch.coef_value <= t.value;
    calibrate(t, has, o);
    if (t.known) o = t.want;
    if (has) expected_ned.push_back(o);
    do @(posedge clk); while (!item_ch.ready);
    n_sent++;
  endtask

  task automatic drop_valid();
    item_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic row_t mk_row(input func_t f, input int x, input int y, input int z,
                                  input int idx, input int value);
    row_t t;
    t = '0;
    t.func = f; t.x = 16'(x); t.y = 16'(y); t.z = 16'(z); t.idx = 5'(idx);
    t.value = value;
    return t;
  endfunction

  function automatic row_t rand_row(input bit mag_heavy);
    row_t t;
    int p;
    t = '0;
    p = $urandom_range(0, 99);
    if (p < 15) begin
      t.func = K_COEF;
      t.idx = 5'(($urandom_range(0, 15) == 0) ? $urandom_range(27, 31)
                                              : $urandom_range(0, 26));
      case ($urandom_range(0, 3))
        0: t.value = $urandom;
        1: t.value = $urandom_range(0, 131072) - 65536;
        2: t.value = ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
        default: t.value = 32'sd65536;
      endcase
    end else begin
      t.func = mag_heavy ? K_MAG : func_t'($urandom_range(0, 2));
      if (p > 95) begin
        t.x = '0; t.y = '0; t.z = '0;
      end else if (p > 90) begin
        t.x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        t.y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        t.z = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end else begin
        t.x = 16'($urandom); t.y = 16'($urandom); t.z = 16'($urandom);
      end
      t.idx = 5'($urandom);
      t.value = $urandom;
    end
    return t;
  endfunction

  row_t dir_rows [$];

  initial begin
    ned_t zero_res;
    row_t t;
    errors = 0; n_sent = 0; n_seen = 0; n_mag = 0; n_zero = 0;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    item_ch.valid = 1'b0; item_ch.func = '0; item_ch.raw_x = '0; item_ch.raw_y = '0;
    item_ch.raw_z = '0; item_ch.coef_index = '0; item_ch.coef_value = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) coef_tab[i] = '0;
    for (int i = 0; i < 3; i++) begin prev_in[i] = 0; prev_out[i] = 0; end
    filt_en = 1'b0; alpha = '0; gscale = '0; ascale = '0; mscale = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset everything scales to zero; mag gives the zero magnitude case
    zero_res = '0;
    t = mk_row(K_GYRO, 32767, -32768, 1, 0, 0); t.known = 1'b1; t.want = zero_res;
    dir_rows.push_back(t);
    t = mk_row(K_ACCEL, -32768, 32767, 0, 0, 0); t.known = 1'b1;
    t.want = zero_res; t.want.kind = K_ACCEL;
    dir_rows.push_back(t);
    t = mk_row(K_MAG, 32767, 32767, -32768, 0, 0); t.known = 1'b1;
    t.want = zero_res; t.want.kind = K_MAG; t.want.zero_norm = 1'b1;
    dir_rows.push_back(t);
    // identity soft-iron matrices, extremes of the table words
    foreach (dir_rows[i]) send(dir_rows[i]);
    dir_rows.delete();
    for (int i = 0; i < 3; i++) begin
      dir_rows.push_back(mk_row(K_COEF, 0, 0, 0, 3 + 4*i, 65536));
      dir_rows.push_back(mk_row(K_COEF, 0, 0, 0, 15 + 4*i, 65536));
    end
    dir_rows.push_back(mk_row(K_COEF, 0, 0, 0, 24, 32'sh7fffffff));
    dir_rows.push_back(mk_row(K_COEF, 0, 0, 0, 26, 32'sh80000000));
    dir_rows.push_back(mk_row(K_COEF, 0, 0, 0, 31, 12345));
    dir_rows.push_back(mk_row(K_COEF, 0, 0, 0, 27, -1));
    dir_rows.push_back(mk_row(K_GYRO, 32767, -32768, 100, 0, 0));
    dir_rows.push_back(mk_row(K_ACCEL, 32767, -32768, -1, 0, 0));
    dir_rows.push_back(mk_row(K_MAG, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(K_MAG, 32767, -32768, 32767, 0, 0));
    foreach (dir_rows[i]) send(dir_rows[i]);
    drop_valid();
    settle();

    // register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          reg_write(REG_FILT_EN, 32'd0); reg_write(REG_ALPHA, 32'd0);
          reg_write(REG_GYRO_SCALE, 32'hffffffff); reg_write(REG_ACCEL_SCALE, 32'hffffffff);
          reg_write(REG_MAG_SCALE, 32'hffffffff);
        end
        1: begin
          reg_write(REG_FILT_EN, 32'd1); reg_write(REG_ALPHA, 32'hffff);
          reg_write(REG_GYRO_SCALE, 32'd1); reg_write(REG_ACCEL_SCALE, 32'd0);
          reg_write(REG_MAG_SCALE, 32'd1 << 28);
        end
        2: begin
          reg_write(REG_ALPHA, 32'd0);
        end
        default: begin
          reg_write(REG_FILT_EN, $urandom_range(0, 1));
          reg_write(REG_ALPHA, $urandom_range(0, 65535));
          reg_write(REG_GYRO_SCALE, $urandom); reg_write(REG_ACCEL_SCALE, $urandom);
          reg_write(REG_MAG_SCALE, $urandom);
        end
      endcase
      for (int k = 0; k < 170; k++) send(rand_row(ph == 1 && k < 40));
      drop_valid();
      settle();
    end

    $display("sent %0d items, checked %0d results (%0d mag, %0d zero magnitude)",
             n_sent, n_seen, n_mag, n_zero);
    $display("six register settings, filter on and off, saturating extremes");
    if (errors == 0 && expected_ned.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d errors, %0d results missing", errors, expected_ned.size());
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
